// ----- rtl/posd_pkg.sv -----
// shared types and constants of the osd palette overlay blender
`timescale 1ns / 1ps
`default_nettype none

package posd_pkg;

    // command carried by each input beat
    typedef enum logic {
        CMD_WRITE = 1'b0,
        CMD_PIXEL = 1'b1
    } t_cmd;

    // blend codes of a palette entry, osd weight rising from 0 to 1
    typedef enum logic [3:0] {
        BLEND_PIC = 4'd0,
        BLEND_1_8 = 4'd1,
        BLEND_1_4 = 4'd2,
        BLEND_1_2 = 4'd3,
        BLEND_3_4 = 4'd4,
        BLEND_7_8 = 4'd5,
        BLEND_OSD = 4'd6
    } t_blend_code;

    localparam int COMP_W  = 8;
    localparam int CODE_W  = 4;
    localparam int INDEX_W = 8;

    // one 24-bit color
    typedef struct packed {
        logic [COMP_W-1:0] red;
        logic [COMP_W-1:0] green;
        logic [COMP_W-1:0] blue;
    } t_color;

    // one 28-bit palette entry
    typedef struct packed {
        logic [CODE_W-1:0] blend;
        t_color            color;
    } t_entry;

    // result of the mixing logic
    typedef struct packed {
        logic   update;  // color is a fresh blend and becomes the last color
        t_color color;
    } t_blend_res;

endpackage

`default_nettype wire

// ----- rtl/posd_palette.sv -----
// palette memory: one write port, one registered read port
`timescale 1ns / 1ps
`default_nettype none

module posd_palette
    import posd_pkg::*;
#(
    parameter int ENTRIES = 256,
    localparam int ADDR_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1
) (
    input  wire logic              i_clk,
    input  wire logic              i_we,
    input  wire logic [ADDR_W-1:0] i_waddr,
    input  wire t_entry            i_wdata,
    input  wire logic              i_re,
    input  wire logic [ADDR_W-1:0] i_raddr,
    output t_entry                 o_rdata
);

    t_entry r_mem [ENTRIES];
    t_entry r_rdata;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // registered read port, holds while not enabled
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

// ----- rtl/posd_blend.sv -----
// per-component mixing of osd and picture color at the palette blend weight
`timescale 1ns / 1ps
`default_nettype none

module posd_blend
    import posd_pkg::*;
(
    input  wire t_color            i_pic,
    input  wire t_color            i_osd,
    input  wire logic [CODE_W-1:0] i_code,
    input  wire logic              i_picture_valid,
    input  wire t_color            i_last_color,
    output t_blend_res             o_res
);

    // mix one component, truncating
    function automatic logic [COMP_W-1:0] mix_comp(
        input logic [COMP_W-1:0] p,
        input logic [COMP_W-1:0] o,
        input logic [CODE_W-1:0] code
    );
        logic [10:0]       p1;
        logic [10:0]       o1;
        logic [10:0]       sum;
        logic [COMP_W-1:0] res;
        p1  = 11'(p);
        o1  = 11'(o);
        sum = '0;
        res = o;
        case (code)
            BLEND_PIC: res = p;
            BLEND_1_8: begin
                sum = (p1 << 3) - p1 + o1;
                res = sum[10:3];
            end
            BLEND_1_4: begin
                sum = (p1 << 1) + p1 + o1;
                res = sum[9:2];
            end
            BLEND_1_2: begin
                sum = p1 + o1;
                res = sum[8:1];
            end
            BLEND_3_4: begin
                sum = p1 + (o1 << 1) + o1;
                res = sum[9:2];
            end
            BLEND_7_8: begin
                sum = p1 + (o1 << 3) - o1;
                res = sum[10:3];
            end
            default: res = o;
        endcase
        return res;
    endfunction

    t_color w_mixed;

    // three components in parallel
    always_comb begin
        w_mixed.blue  = mix_comp(i_pic.blue,  i_osd.blue,  i_code);
        w_mixed.green = mix_comp(i_pic.green, i_osd.green, i_code);
        w_mixed.red   = mix_comp(i_pic.red,   i_osd.red,   i_code);
    end

    // choose osd pass-through, fresh blend or repeat of the last blend
    always_comb begin
        o_res.update = 1'b0;
        if (!i_picture_valid) begin
            o_res.color = i_osd;
        end else if (i_code <= CODE_W'(BLEND_OSD)) begin
            o_res.color  = w_mixed;
            o_res.update = 1'b1;
        end else begin
            o_res.color = i_last_color;
        end
    end

endmodule

`default_nettype wire

// ----- rtl/palette_osd_alpha_blend_unit.sv -----
// top level of the osd palette overlay blender
//
// Input channel (i_in_valid / o_in_stall) carries one beat per item. A beat
// with i_cmd = write stores blue, green, red and blend code at i_color_index
// and gives no result; a beat with i_cmd = pixel looks up i_color_index and
// mixes that osd color with the picture pixel at the entry's weight.
// Output channel (o_out_valid / i_out_stall) carries one beat per pixel.
// i_cfg_we / i_cfg_wdata write picture_valid; with it low the palette color
// passes through unchanged.
// Pipeline: an accepted pixel passes the palette read register, then the
// output register. Throughput is one beat per cycle while the receiver
// does not stall: the palette read register and the output register form
// two stages that advance together.
// Reset clears the pipeline valids and the last blended color and sets
// picture_valid. Palette contents are undefined until written.
// When the receiver stalls with a result waiting, the whole pipe holds and
// o_in_stall rises in the same cycle; nothing is dropped.
`timescale 1ns / 1ps
`default_nettype none

module palette_osd_alpha_blend_unit
    import posd_pkg::*;
#(
    parameter int PALETTE_ENTRIES = 256
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    // configuration
    input  wire logic               i_cfg_we,
    input  wire logic               i_cfg_wdata,
    // input channel
    input  wire logic               i_in_valid,
    output logic                    o_in_stall,
    input  wire logic               i_cmd,
    input  wire logic [INDEX_W-1:0] i_color_index,
    input  wire logic [COMP_W-1:0]  i_pic_blue,
    input  wire logic [COMP_W-1:0]  i_pic_green,
    input  wire logic [COMP_W-1:0]  i_pic_red,
    input  wire logic [COMP_W-1:0]  i_entry_blue,
    input  wire logic [COMP_W-1:0]  i_entry_green,
    input  wire logic [COMP_W-1:0]  i_entry_red,
    input  wire logic [CODE_W-1:0]  i_entry_blend,
    // output channel
    output logic                    o_out_valid,
    input  wire logic               i_out_stall,
    output logic [COMP_W-1:0]       o_out_blue,
    output logic [COMP_W-1:0]       o_out_green,
    output logic [COMP_W-1:0]       o_out_red
);

    localparam int ADDR_W = (PALETTE_ENTRIES > 1) ? $clog2(PALETTE_ENTRIES) : 1;
    localparam logic [INDEX_W:0] ENTRIES_LIM = (INDEX_W + 1)'(PALETTE_ENTRIES);

    logic       r_picture_valid;
    logic       r_s1_valid;
    logic       r_s1_oob;
    t_color     r_s1_pic;
    t_color     r_last_color;
    logic       r_out_valid;
    t_color     r_out_color;

    logic       w_advance;
    logic       w_accept;
    logic       w_in_range;
    t_entry     w_wdata;
    t_entry     w_rdata;
    t_entry     w_entry;
    t_color     w_pic;
    t_blend_res w_res;
    t_color     n_last_color;

    // pipe moves unless a finished result is held by the receiver
    assign w_advance  = !(r_out_valid && i_out_stall);
    assign o_in_stall = !w_advance;
    assign w_accept   = i_in_valid && w_advance;
    assign w_in_range = {1'b0, i_color_index} < ENTRIES_LIM;

    // configuration register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_picture_valid <= 1'b1;
        end else if (i_cfg_we) begin
            r_picture_valid <= i_cfg_wdata;
        end
    end

    // palette store
    always_comb begin
        w_wdata.blend       = i_entry_blend;
        w_wdata.color.blue  = i_entry_blue;
        w_wdata.color.green = i_entry_green;
        w_wdata.color.red   = i_entry_red;
        w_pic.blue          = i_pic_blue;
        w_pic.green         = i_pic_green;
        w_pic.red           = i_pic_red;
    end

    posd_palette #(
        .ENTRIES (PALETTE_ENTRIES)
    ) u_palette (
        .i_clk   (i_clk),
        .i_we    (w_accept && (i_cmd == CMD_WRITE) && w_in_range),
        .i_waddr (i_color_index[ADDR_W-1:0]),
        .i_wdata (w_wdata),
        .i_re    (w_accept && (i_cmd == CMD_PIXEL)),
        .i_raddr (i_color_index[ADDR_W-1:0]),
        .o_rdata (w_rdata)
    );

    // lookup stage: pixel beats only
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (w_advance) begin
            r_s1_valid <= i_in_valid && (i_cmd == CMD_PIXEL);
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept && (i_cmd == CMD_PIXEL)) begin
            r_s1_oob <= !w_in_range;
            r_s1_pic <= w_pic;
        end
    end

    // an index beyond the palette reads as an all-zero entry
    assign w_entry = r_s1_oob ? '0 : w_rdata;

    posd_blend u_blend (
        .i_pic           (r_s1_pic),
        .i_osd           (w_entry.color),
        .i_code          (w_entry.blend),
        .i_picture_valid (r_picture_valid),
        .i_last_color    (r_last_color),
        .o_res           (w_res)
    );

    // last blended color follows each fresh blend that leaves the stage
    always_comb begin
        n_last_color = r_last_color;
        if (w_advance && r_s1_valid && w_res.update) begin
            n_last_color = w_res.color;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_last_color <= '0;
        end else begin
            r_last_color <= n_last_color;
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_advance) begin
            r_out_valid <= r_s1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_advance && r_s1_valid) begin
            r_out_color <= w_res.color;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_blue  = r_out_color.blue;
    assign o_out_green = r_out_color.green;
    assign o_out_red   = r_out_color.red;

    // a pixel leaving the lookup stage is on the output next cycle
    a_s1_to_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s1_valid && w_advance) |=> r_out_valid)
        else $error("pixel lost between lookup and output");

    // a palette write never enters the lookup stage
    a_write_no_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && (i_cmd == CMD_WRITE)) |=> !r_s1_valid)
        else $error("palette write produced a result");

    // last color moves only on a fresh blend with the picture enabled
    a_last_color: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !$stable(r_last_color) |-> $past(r_s1_valid && w_advance && r_picture_valid))
        else $error("last color changed without a blend");

endmodule

`default_nettype wire
